// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Field widths of the channels and the configuration port.
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int POS_W      = 14;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int PROD_W     = ROW_W + COL_W;
    localparam int LIN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Blank cell: space with light gray on black.
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    // Screen geometry limits and reset values.
    localparam logic [COL_W-1:0] MIN_WIDTH    = 8'd40;
    localparam logic [ROW_W-1:0] MIN_HEIGHT   = 6'd10;
    localparam logic [COL_W-1:0] RESET_WIDTH  = 8'd80;
    localparam logic [ROW_W-1:0] RESET_HEIGHT = 6'd25;

    // Requests to the cell store.
    typedef struct packed {
        logic              en;
        logic [LIN_W-1:0]  addr;
        logic [CELL_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [LIN_W-1:0] addr;
    } t_rd_req;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tcw_cmd_if import tcw_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] color;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (
        output valid, command, char_code, color, read_row, read_col,
        input  ready
    );

    modport sink (
        input  valid, command, char_code, color, read_row, read_col,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/tcw_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tcw_rsp_if import tcw_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_color;

    modport source (
        output valid, cursor_row, cursor_col, cursor_position, cell_char, cell_color,
        input  ready
    );

    modport sink (
        input  valid, cursor_row, cursor_col, cursor_position, cell_char, cell_color,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Text console engine. Each transfer on i_cmd either prints one character at
// the cursor (newline, carriage return, backspace and tab are interpreted) or
// reads back one cell; each gives one transfer on o_rsp with the cursor after
// the item and, for a read, the cell. The cells live in one memory with a
// write port and a registered read port, one cell per cycle. After reset the
// block blanks all CELL_COUNT cells of the memory before it takes a command;
// configuration writes are taken at any time. Scrolling copies every line of
// the screen but the top one up by one line through the memory port, then
// blanks the bottom line. A new command is taken while the previous result
// still waits on o_rsp.

module text_console_char_writer import tcw_pkg::*; #(
    parameter int unsigned CELL_COUNT = 16384,
    parameter int unsigned MAX_WIDTH  = 200,
    parameter int unsigned MAX_HEIGHT = 60,
    parameter int unsigned TAB_SPACES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tcw_cmd_if.sink               i_cmd,
    tcw_rsp_if.source             o_rsp
);

    localparam int unsigned LEFT_W = $clog2(TAB_SPACES + 1);
    localparam logic [COL_W-1:0] W_MAX = COL_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] H_MAX = ROW_W'(MAX_HEIGHT);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RMUL,
        S_RREAD,
        S_BASE,
        S_PUT,
        S_SCSET,
        S_SCOPY,
        S_SBLANK,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [COL_W-1:0]    r_width;
    logic [ROW_W-1:0]    r_height;
    logic [ROW_W-1:0]    r_line;
    logic [COL_W-1:0]    r_col;
    logic [LIN_W-1:0]    r_base;
    logic [LIN_W-1:0]    r_a;
    logic [LEFT_W-1:0]   r_left;
    logic [CHAR_W-1:0]   r_ch;
    logic [ATTR_W-1:0]   r_color;
    logic [ROW_W-1:0]    r_rrow;
    logic [COL_W-1:0]    r_rcol;
    logic                r_rd_ok;
    logic                r_pend;
    logic [LIN_W-1:0]    r_pend_addr;
    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic [POS_W-1:0]    r_out_pos;
    logic [CHAR_W-1:0]   r_out_char;
    logic [ATTR_W-1:0]   r_out_color;

    logic [COL_W-1:0]    w_use;
    logic [ROW_W-1:0]    h_use;
    logic [ROW_W-1:0]    mul_row;
    logic [PROD_W-1:0]   mul_prod;
    logic [LIN_W-1:0]    lin;
    logic [LIN_W-1:0]    bs_addr;
    logic [LIN_W-1:0]    copy_src;
    logic [LIN_W-1:0]    blank_last;
    logic [COL_W-1:0]    col_inc;
    logic [ROW_W-1:0]    line_inc;
    logic [ROW_W-1:0]    sat_line;
    logic [COL_W-1:0]    sat_col;
    logic                cmd_xfer;
    logic                copy_more;
    logic [CELL_W-1:0]   rd_data;
    t_wr_req             wr_req;
    t_rd_req             rd_req;

    // Screen geometry in use, clamped to the supported range.
    always_comb begin
        if (r_width < MIN_WIDTH) begin
            w_use = MIN_WIDTH;
        end else if (r_width > W_MAX) begin
            w_use = W_MAX;
        end else begin
            w_use = r_width;
        end
        if (r_height < MIN_HEIGHT) begin
            h_use = MIN_HEIGHT;
        end else if (r_height > H_MAX) begin
            h_use = H_MAX;
        end else begin
            h_use = r_height;
        end
    end

    // One shared row-times-width multiplier.
    always_comb begin
        case (r_state)
            S_RMUL:  mul_row = r_rrow;
            S_SCSET: mul_row = h_use - ROW_W'(1);
            default: mul_row = r_line;
        endcase
    end

    assign mul_prod = PROD_W'(mul_row) * PROD_W'(w_use);

    // Cursor arithmetic.
    assign lin        = r_base + LIN_W'(r_col);
    assign bs_addr    = (lin == '0) ? '0 : lin - LIN_W'(1);
    assign copy_src   = r_a + LIN_W'(w_use);
    assign blank_last = r_base + LIN_W'(w_use) - LIN_W'(1);
    assign col_inc    = r_col + COL_W'(1);
    assign line_inc   = r_line + ROW_W'(1);
    assign sat_line   = (r_line >= h_use) ? h_use - ROW_W'(1) : r_line;
    assign sat_col    = (r_col >= w_use) ? w_use - COL_W'(1) : r_col;
    assign copy_more  = r_a < r_base;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;

    // Write port: a pending scroll copy has priority, it never meets another write.
    always_comb begin
        wr_req = '0;
        if (r_pend) begin
            wr_req.en   = 1'b1;
            wr_req.addr = r_pend_addr;
            wr_req.data = rd_data;
        end else begin
            case (r_state)
                S_CLEAR, S_SBLANK: begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = r_a;
                    wr_req.data = BLANK_CELL;
                end
                S_PUT: begin
                    wr_req.en = (r_ch != CH_NEWLINE) && (r_ch != CH_RETURN);
                    if (r_ch == CH_BACKSPACE) begin
                        wr_req.addr = bs_addr;
                        wr_req.data = {r_color, CH_SPACE};
                    end else begin
                        wr_req.addr = lin;
                        wr_req.data = {r_color, r_ch};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read port: the cell read command and the source row of a scroll.
    always_comb begin
        rd_req = '0;
        case (r_state)
            S_RREAD: begin
                rd_req.en   = r_rd_ok;
                rd_req.addr = r_base + LIN_W'(r_rcol);
            end
            S_SCOPY: begin
                rd_req.en   = copy_more;
                rd_req.addr = copy_src;
            end
            default: begin
            end
        endcase
    end

    tcw_cell_store #(
        .CELL_COUNT (CELL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (wr_req),
        .i_rd    (rd_req),
        .o_rdata (rd_data)
    );

    // Sequencer, cursor, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_line      <= '0;
            r_col       <= '0;
            r_a         <= '0;
            r_left      <= '0;
            r_rd_ok     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data[COL_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                    default: begin
                    end
                endcase
            end

            // The result leaves on a transfer; the finishing step reloads it itself.
            if (r_out_valid && o_rsp.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_a <= r_a + LIN_W'(1);
                    if (r_a == LIN_W'(CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (cmd_xfer) begin
                        r_line  <= sat_line;
                        r_col   <= sat_col;
                        r_color <= i_cmd.color;
                        r_rrow  <= i_cmd.read_row;
                        r_rcol  <= i_cmd.read_col;
                        if (i_cmd.command == CMD_READ) begin
                            r_rd_ok <= (i_cmd.read_row < h_use) && (i_cmd.read_col < w_use);
                            r_left  <= '0;
                            r_state <= S_RMUL;
                        end else begin
                            r_rd_ok <= 1'b0;
                            if (i_cmd.char_code == CH_TAB) begin
                                r_ch   <= CH_SPACE;
                                r_left <= LEFT_W'(TAB_SPACES);
                            end else begin
                                r_ch   <= i_cmd.char_code;
                                r_left <= LEFT_W'(1);
                            end
                            r_state <= S_BASE;
                        end
                    end
                end

                S_RMUL: begin
                    r_base  <= LIN_W'(mul_prod);
                    r_state <= S_RREAD;
                end

                S_RREAD: begin
                    r_state <= S_BASE;
                end

                S_BASE: begin
                    r_base  <= LIN_W'(mul_prod);
                    r_state <= (r_left != '0) ? S_PUT : S_FIN;
                end

                S_PUT: begin
                    r_left <= r_left - LEFT_W'(1);
                    case (r_ch)
                        CH_NEWLINE: begin
                            r_col <= '0;
                            if (line_inc >= h_use) begin
                                r_state <= S_SCSET;
                            end else begin
                                r_line  <= line_inc;
                                r_state <= S_BASE;
                            end
                        end
                        CH_RETURN: begin
                            r_col   <= '0;
                            r_state <= S_BASE;
                        end
                        CH_BACKSPACE: begin
                            if (r_col != '0) begin
                                r_col <= r_col - COL_W'(1);
                            end else if (r_line != '0) begin
                                r_line <= r_line - ROW_W'(1);
                                r_col  <= w_use - COL_W'(1);
                            end
                            r_state <= S_BASE;
                        end
                        default: begin
                            if (col_inc >= w_use) begin
                                r_col <= '0;
                                if (line_inc >= h_use) begin
                                    r_state <= S_SCSET;
                                end else begin
                                    r_line  <= line_inc;
                                    r_state <= S_BASE;
                                end
                            end else begin
                                r_col   <= col_inc;
                                r_state <= S_BASE;
                            end
                        end
                    endcase
                end

                // Scroll: r_base holds the start of the bottom line.
                S_SCSET: begin
                    r_base  <= LIN_W'(mul_prod);
                    r_a     <= '0;
                    r_state <= S_SCOPY;
                end

                S_SCOPY: begin
                    if (copy_more) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_a;
                        r_a         <= r_a + LIN_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_SBLANK;
                    end
                end

                S_SBLANK: begin
                    r_a <= r_a + LIN_W'(1);
                    if (r_a == blank_last) begin
                        r_line  <= h_use - ROW_W'(1);
                        r_col   <= '0;
                        r_state <= S_BASE;
                    end
                end

                S_FIN: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_line;
                        r_out_col   <= r_col;
                        r_out_pos   <= lin[POS_W-1:0];
                        r_out_char  <= r_rd_ok ? rd_data[CHAR_W-1:0] : '0;
                        r_out_color <= r_rd_ok ? rd_data[CELL_W-1:CHAR_W] : '0;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cursor_row      = r_out_row;
    assign o_rsp.cursor_col      = r_out_col;
    assign o_rsp.cursor_position = r_out_pos;
    assign o_rsp.cell_char       = r_out_char;
    assign o_rsp.cell_color      = r_out_color;

    // A scroll copy write is only ever outstanding inside the copy phase.
    a_pend_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCOPY))
        else $error("scroll copy write outstanding outside the copy phase");

    // A command transfer always starts work on the item.
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer |=> ((r_state == S_RMUL) || (r_state == S_BASE)))
        else $error("command transfer did not start an item");

    // A new result only appears from the finishing step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finishing step");

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_cell_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_store import tcw_pkg::*; #(
    parameter int unsigned CELL_COUNT = 16384
) (
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  t_rd_req           i_rd,
    output logic [CELL_W-1:0] o_rdata
);

    localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_q;
    logic              r_hit;
    logic              wr_hit;
    logic              rd_hit;

    // Addresses past the end of the store are dropped on write and read as zero.
    assign wr_hit = 32'(i_wr.addr) < CELL_COUNT;
    assign rd_hit = 32'(i_rd.addr) < CELL_COUNT;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_hit) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q   <= r_mem[i_rd.addr[AW-1:0]];
            r_hit <= rd_hit;
        end
    end

    assign o_rdata = r_hit ? r_q : '0;

endmodule

`default_nettype wire
